FILE: sv/gamepad_serial_poll_responder_core_macros.svh
// Assertion macros shared by the gamepad poll responder.
`ifndef GAMEPAD_SERIAL_POLL_RESPONDER_CORE_MACROS_SVH
`define GAMEPAD_SERIAL_POLL_RESPONDER_CORE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define GSP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that a trigger is followed by a condition in the next cycle.
`define GSP_ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) trig |=> cond) else $error(msg);

`endif

FILE: sv/gsp_pkg.sv
// Types, command codes and reply tables of the gamepad poll responder.
package gsp_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_END   = 2'd2,
    OP_PAD   = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic [4:0] pad_index;
    logic [7:0] pad_value;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic [7:0] motor_small_drive;
    logic [7:0] motor_large_drive;
    logic       analog_on;
    logic       config_on;
    logic       mode_lock_on;
    logic       pressure_on;
    logic [7:0] device_id;
    logic [4:0] poll_length;
  } result_t;

  // Host command codes.
  localparam logic [7:0] CMD_ATTR_READ = 8'h40;
  localparam logic [7:0] CMD_CAPS      = 8'h41;
  localparam logic [7:0] CMD_POLL      = 8'h42;
  localparam logic [7:0] CMD_ENTER_CFG = 8'h43;
  localparam logic [7:0] CMD_SET_MODE  = 8'h44;
  localparam logic [7:0] CMD_STATUS    = 8'h45;
  localparam logic [7:0] CMD_CONST_46  = 8'h46;
  localparam logic [7:0] CMD_CONST_47  = 8'h47;
  localparam logic [7:0] CMD_CONST_48  = 8'h48;
  localparam logic [7:0] CMD_CONST_4C  = 8'h4C;
  localparam logic [7:0] CMD_MOTOR_MAP = 8'h4D;
  localparam logic [7:0] CMD_RESP_MASK = 8'h4F;

  // Header and identity bytes.
  localparam logic [7:0] HDR_ADDR     = 8'h01;
  localparam logic [7:0] HDR_MARK     = 8'h5A;
  localparam logic [7:0] IDLE_BYTE    = 8'hFF;
  localparam logic [7:0] ID_CONFIG    = 8'hF3;
  localparam logic [7:0] ID_DIGITAL   = 8'h41;
  localparam logic [7:0] ID_ANALOG    = 8'h73;
  localparam logic [7:0] ID_PRESSURE  = 8'h79;
  localparam int         AttrCount    = 12;

  // Six-byte reply tables, element 0 goes out at position 3.
  localparam logic [5:0][7:0] TBL_CAPS = {8'h00, 8'h00, 8'h00, 8'h03, 8'hFF, 8'hFF};
  localparam logic [5:0][7:0] TBL_46A  = {8'h0A, 8'h00, 8'h02, 8'h01, 8'h00, 8'h00};
  localparam logic [5:0][7:0] TBL_46B  = {8'h14, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00};
  localparam logic [5:0][7:0] TBL_47   = {8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00};

  // Picks the table byte for positions 3 to 8, zero beyond.
  function automatic logic [7:0] six_pick(input logic [5:0][7:0] t, input logic [7:0] p);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 6; i++) begin
      if (p == 8'(i + 3)) r = t[i];
    end
    return r;
  endfunction

endpackage

FILE: sv/gsp_engine.sv
// Protocol state and reply byte logic of the gamepad poll responder.
module gsp_engine #(
  parameter int PRESSURE_BYTES = 12,
  parameter int MAP_BYTES      = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  gsp_pkg::item_t   item_i,
  output gsp_pkg::result_t result_o
);

  localparam int         PadCount     = 6 + PRESSURE_BYTES;
  localparam logic [4:0] PollLenPress = 5'(9 + PRESSURE_BYTES);

  logic analog_q, analog_d, lock_q, lock_d, config_q, config_d, pressure_q, pressure_d;
  logic [7:0] pad_q [PadCount];
  logic [7:0] pad_d [PadCount];
  logic [7:0] mmap_q [MAP_BYTES];
  logic [7:0] mmap_d [MAP_BYTES];
  logic [7:0] rmask_q [MAP_BYTES];
  logic [7:0] rmask_d [MAP_BYTES];
  logic [7:0] saved_q [MAP_BYTES];
  logic [7:0] saved_d [MAP_BYTES];
  logic [7:0] stmm_q [MAP_BYTES];
  logic [7:0] stmm_d [MAP_BYTES];
  logic [7:0] strm_q [MAP_BYTES];
  logic [7:0] strm_d [MAP_BYTES];
  logic [1:0] attr_q [gsp_pkg::AttrCount];
  logic [1:0] attr_d [gsp_pkg::AttrCount];
  logic [7:0] small_q, small_d, large_q, large_d, pos_q, pos_d;
  logic       addr_q, addr_d, cfgst_q, cfgst_d;
  logic [7:0] cmd_q, cmd_d, arg_q, arg_d, ntx_q, ntx_d;
  logic [5:0] stf_q, stf_d;

  logic [7:0] rx, dq, pd, pad_at, attr_at, reply, poll_b, cfg_b, saved_at, id_q, id_d;
  logic [7:0] m0, m1, m2;

  // Next state for one accepted transaction.
  always_comb begin
    analog_d = analog_q; lock_d = lock_q; config_d = config_q; pressure_d = pressure_q;
    pad_d = pad_q; mmap_d = mmap_q; rmask_d = rmask_q; saved_d = saved_q;
    stmm_d = stmm_q; strm_d = strm_q; attr_d = attr_q;
    small_d = small_q; large_d = large_q; pos_d = pos_q;
    addr_d = addr_q; cfgst_d = cfgst_q; cmd_d = cmd_q; arg_d = arg_q; stf_d = stf_q;
    rx = item_i.data_byte;
    dq = pos_q - 8'd3;
    m0 = 8'h00; m1 = 8'h00; m2 = 8'h00;
    for (int i = 0; i < MAP_BYTES; i++) begin
      if (i == 0) m0 = strm_q[i];
      if (i == 1) m1 = strm_q[i];
      if (i == 2) m2 = strm_q[i];
    end
    if (fire_i) begin
      case (item_i.op)
        gsp_pkg::OP_START: begin
          pos_d = 8'd0; addr_d = 1'b0; cmd_d = 8'd0; arg_d = 8'd0;
          cfgst_d = config_q; stf_d = 6'd0;
          saved_d = mmap_q; stmm_d = mmap_q; strm_d = rmask_q;
        end
        gsp_pkg::OP_BYTE: begin
          if (pos_q == 8'd3) arg_d = rx;
          if (pos_q == 8'd0) begin
            addr_d = (rx == gsp_pkg::HDR_ADDR);
          end else if (pos_q == 8'd1 && addr_q) begin
            cmd_d = rx;
          end else if (addr_q && pos_q >= 8'd3) begin
            case (cmd_q)
              gsp_pkg::CMD_POLL: begin
                for (int i = 0; i < MAP_BYTES; i++) begin
                  if (dq == 8'(i)) begin
                    if (mmap_q[i] == 8'h00) small_d = (rx == 8'hFF) ? 8'hFF : 8'h00;
                    if (mmap_q[i] == 8'h01) large_d = rx;
                  end
                end
              end
              gsp_pkg::CMD_ENTER_CFG: begin
                if (pos_q == 8'd3) stf_d[1:0] = {rx == 8'h01, 1'b1};
              end
              gsp_pkg::CMD_SET_MODE: begin
                if (pos_q == 8'd3 && rx <= 8'd1) stf_d[3:2] = {rx == 8'h01, 1'b1};
                if (pos_q == 8'd4) stf_d[5:4] = {rx[1:0] == 2'b11, 1'b1};
              end
              gsp_pkg::CMD_MOTOR_MAP: begin
                for (int i = 0; i < MAP_BYTES; i++) begin
                  if (dq == 8'(i)) stmm_d[i] = rx;
                end
              end
              gsp_pkg::CMD_RESP_MASK: begin
                for (int i = 0; i < MAP_BYTES; i++) begin
                  if (dq == 8'(i)) strm_d[i] = rx;
                end
              end
              gsp_pkg::CMD_ATTR_READ: begin
                for (int i = 0; i < gsp_pkg::AttrCount; i++) begin
                  if (pos_q == 8'd4 && arg_q == 8'(i)) attr_d[i] = rx[1:0];
                end
              end
              default: ;
            endcase
          end
          pos_d = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
        end
        gsp_pkg::OP_END: begin
          if (addr_q) begin
            if (cmd_q == gsp_pkg::CMD_MOTOR_MAP && cfgst_q) mmap_d = stmm_q;
            if (cmd_q == gsp_pkg::CMD_RESP_MASK && cfgst_q) begin
              rmask_d = strm_q;
              pressure_d = (m0[7:6] != 2'b00) || (m1 != 8'h00) || (m2[1:0] != 2'b00);
            end
            if (cmd_q == gsp_pkg::CMD_SET_MODE && cfgst_q) begin
              if (stf_q[2]) analog_d = stf_q[3];
              if (stf_q[4]) lock_d = stf_q[5];
              if (!analog_d) pressure_d = 1'b0;
            end
            if (cmd_q == gsp_pkg::CMD_ENTER_CFG && stf_q[0]) config_d = stf_q[1];
          end
          addr_d = 1'b0;
        end
        default: begin
          for (int i = 0; i < PadCount; i++) begin
            if (item_i.pad_index == 5'(i)) pad_d[i] = item_i.pad_value;
          end
        end
      endcase
    end
  end

  // Byte lookups at the new position.
  always_comb begin
    pd = pos_d - 8'd3;
    pad_at = 8'h00;
    saved_at = 8'h00;
    attr_at = 8'hFF;
    for (int i = 0; i < PadCount; i++) begin
      if (pd == 8'(i)) pad_at = pad_q[i];
    end
    for (int i = 0; i < MAP_BYTES; i++) begin
      if (pd == 8'(i)) saved_at = saved_q[i];
    end
    for (int i = 0; i < gsp_pkg::AttrCount; i++) begin
      if (arg_d == 8'(i)) attr_at = {6'd0, attr_d[i]};
    end
  end

  // Poll data byte.
  always_comb begin
    if (pos_d == 8'd3 || pos_d == 8'd4) begin
      poll_b = pad_at;
    end else if (!analog_q) begin
      poll_b = 8'hFF;
    end else if (pos_d >= 8'd5 && pos_d <= 8'd8) begin
      poll_b = pad_at;
    end else if (pressure_q && pos_d >= 8'd9 && pos_d < 8'(9 + PRESSURE_BYTES)) begin
      poll_b = pad_at;
    end else begin
      poll_b = 8'h00;
    end
  end

  // Configuration command reply byte.
  always_comb begin
    cfg_b = 8'h00;
    if (pos_d >= 8'd3) begin
      case (cmd_d)
        gsp_pkg::CMD_ATTR_READ: if (pos_d == 8'd5) cfg_b = attr_at;
        gsp_pkg::CMD_CAPS:      cfg_b = gsp_pkg::six_pick(gsp_pkg::TBL_CAPS, pos_d);
        gsp_pkg::CMD_ENTER_CFG: begin
          if (!cfgst_q) begin
            if (pos_d == 8'd3 || pos_d == 8'd4) cfg_b = pad_at;
            else if (analog_q && pos_d >= 8'd5 && pos_d <= 8'd8) cfg_b = pad_at;
          end
        end
        gsp_pkg::CMD_SET_MODE:  if (pos_d == 8'd5 && arg_d > 8'd1) cfg_b = 8'hFF;
        gsp_pkg::CMD_STATUS:
          cfg_b = gsp_pkg::six_pick({8'h00, 8'h01, 8'h02, {7'd0, analog_q}, 8'h02, 8'h03},
                                    pos_d);
        gsp_pkg::CMD_CONST_46: begin
          if (arg_d == 8'd0) cfg_b = gsp_pkg::six_pick(gsp_pkg::TBL_46A, pos_d);
          else if (arg_d == 8'd1) cfg_b = gsp_pkg::six_pick(gsp_pkg::TBL_46B, pos_d);
        end
        gsp_pkg::CMD_CONST_47:  cfg_b = gsp_pkg::six_pick(gsp_pkg::TBL_47, pos_d);
        gsp_pkg::CMD_CONST_48:  if (pos_d == 8'd7 && arg_d <= 8'd1) cfg_b = 8'h01;
        gsp_pkg::CMD_CONST_4C: begin
          if (pos_d == 8'd6) begin
            if (arg_d == 8'd0) cfg_b = 8'h04;
            else if (arg_d == 8'd1) cfg_b = 8'h07;
          end
        end
        gsp_pkg::CMD_MOTOR_MAP: cfg_b = saved_at;
        gsp_pkg::CMD_RESP_MASK: if (pos_d == 8'd8) cfg_b = gsp_pkg::HDR_MARK;
        default: cfg_b = 8'h00;
      endcase
    end
  end

  // Current identity before and after the transaction.
  assign id_q = config_q ? gsp_pkg::ID_CONFIG :
                (!analog_q ? gsp_pkg::ID_DIGITAL :
                 (pressure_q ? gsp_pkg::ID_PRESSURE : gsp_pkg::ID_ANALOG));
  assign id_d = config_d ? gsp_pkg::ID_CONFIG :
                (!analog_d ? gsp_pkg::ID_DIGITAL :
                 (pressure_d ? gsp_pkg::ID_PRESSURE : gsp_pkg::ID_ANALOG));

  // Reply byte for the next exchange.
  always_comb begin
    if (!addr_d || pos_d == 8'd0) reply = gsp_pkg::IDLE_BYTE;
    else if (pos_d == 8'd1) reply = cfgst_q ? gsp_pkg::ID_CONFIG : id_q;
    else if (pos_d == 8'd2) reply = gsp_pkg::HDR_MARK;
    else if (cmd_d == gsp_pkg::CMD_POLL) reply = poll_b;
    else if (!cfgst_q && cmd_d != gsp_pkg::CMD_ENTER_CFG) reply = 8'h00;
    else reply = cfg_b;
  end

  // Transmit byte register update.
  always_comb begin
    ntx_d = ntx_q;
    if (fire_i) begin
      case (item_i.op)
        gsp_pkg::OP_BYTE: ntx_d = reply;
        gsp_pkg::OP_PAD:  ntx_d = ntx_q;
        default:          ntx_d = gsp_pkg::IDLE_BYTE;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      analog_q <= 1'b1; lock_q <= 1'b1; config_q <= 1'b0; pressure_q <= 1'b0;
      for (int i = 0; i < PadCount; i++) begin
        pad_q[i] <= (i < 2) ? 8'hFF : ((i < 6) ? 8'h80 : 8'h00);
      end
      for (int i = 0; i < MAP_BYTES; i++) begin
        mmap_q[i] <= 8'hFF;
        rmask_q[i] <= (i == 0) ? 8'h3F : 8'h00;
        saved_q[i] <= 8'h00; stmm_q[i] <= 8'h00; strm_q[i] <= 8'h00;
      end
      for (int i = 0; i < gsp_pkg::AttrCount; i++) attr_q[i] <= 2'd2;
      small_q <= 8'h00; large_q <= 8'h00; pos_q <= 8'h00;
      addr_q <= 1'b0; cfgst_q <= 1'b0; cmd_q <= 8'h00; arg_q <= 8'h00;
      stf_q <= 6'd0; ntx_q <= gsp_pkg::IDLE_BYTE;
    end else begin
      analog_q <= analog_d; lock_q <= lock_d; config_q <= config_d; pressure_q <= pressure_d;
      pad_q <= pad_d; mmap_q <= mmap_d; rmask_q <= rmask_d; saved_q <= saved_d;
      stmm_q <= stmm_d; strm_q <= strm_d; attr_q <= attr_d;
      small_q <= small_d; large_q <= large_d; pos_q <= pos_d;
      addr_q <= addr_d; cfgst_q <= cfgst_d; cmd_q <= cmd_d; arg_q <= arg_d;
      stf_q <= stf_d; ntx_q <= ntx_d;
    end
  end

  // Result of the transaction, taken from the updated state.
  always_comb begin
    result_o.tx_byte           = ntx_d;
    result_o.motor_small_drive = small_d;
    result_o.motor_large_drive = large_d;
    result_o.analog_on         = analog_d;
    result_o.config_on         = config_d;
    result_o.mode_lock_on      = lock_d;
    result_o.pressure_on       = pressure_d;
    result_o.device_id         = id_d;
    result_o.poll_length       = !analog_d ? 5'd5 : (pressure_d ? PollLenPress : 5'd9);
  end

endmodule

FILE: sv/gamepad_serial_poll_responder_core.sv
// Top level of the gamepad poll responder: input register, engine, result register.
//
// The host side presents one protocol event per input transaction: frame
// start, one exchanged byte, frame end, or a pad value write. Each accepted
// transaction yields exactly one result transaction carrying the byte to send
// at the next exchange, the rumble drive levels and the mode flags.
// An accepted transaction sits in the input register; when the engine fires,
// it updates its state and loads the result register together. Throughput is
// one transaction per cycle while the receiver does not stall the result
// register.
// When the receiver stalls, the result register holds its transaction and
// one further input transaction waits in the input register; only then does
// the input stall rise.
// Reset clears both valid flags and puts the engine in its power-up mode:
// analog on, mode lock on, configuration off, neutral pad values.
module gamepad_serial_poll_responder_core #(
  parameter int PRESSURE_BYTES = 12,
  parameter int MAP_BYTES      = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  gsp_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gsp_pkg::result_t out_item_o
);

  `include "gamepad_serial_poll_responder_core_macros.svh"

  logic             in_vld_q;
  gsp_pkg::item_t   in_q;
  logic             out_vld_q;
  gsp_pkg::result_t out_q;
  gsp_pkg::result_t res;
  logic             fire;

  // The engine runs when the result register is free or being emptied.
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;

  gsp_engine #(
    .PRESSURE_BYTES(PRESSURE_BYTES),
    .MAP_BYTES     (MAP_BYTES)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_q),
    .result_o(res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Checks on the block's own logic.
  `GSP_ASSERT(a_stall_only_when_full, clk_i, rst_ni, in_stall_o |-> (out_vld_q && out_stall_i), "input stalled while result register free")
  `GSP_ASSERT_NEXT(a_end_idle_byte, clk_i, rst_ni, (fire && in_q.op == gsp_pkg::OP_END), (out_q.tx_byte == gsp_pkg::IDLE_BYTE), "frame end did not reply idle byte")
  `GSP_ASSERT(a_small_motor_level, clk_i, rst_ni, out_vld_q |-> (out_q.motor_small_drive == 8'h00 || out_q.motor_small_drive == 8'hFF), "small motor level not on or off")

endmodule

FILE: tb/sv/tb_gamepad_serial_poll_responder_core.sv
// Self-checking testbench for the gamepad poll responder: directed table, random frames.
module tb_gamepad_serial_poll_responder_core;
  import gsp_pkg::*;

  // One directed row: the event and, where obvious, its typed reply.
  typedef struct {
    item_t   ev;
    bit      typed;
    result_t res;
  } row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  item_t   in_item_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  result_t out_item_o;

  gamepad_serial_poll_responder_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the responder.
  bit       analog_s, lock_s, config_s, pressure_s;
  bit [7:0] pad_s [18];
  bit [7:0] map_s [6];
  bit [7:0] mask_s [6];
  bit [1:0] attr_s [12];
  bit [7:0] small_s, large_s, pos_s, cmd_s, arg_s, tx_s;
  bit       addressed_s, cfg_start_s;
  bit [7:0] saved_map_s [6];
  bit [7:0] staged_map_s [6];
  bit [7:0] staged_mask_s [6];
  bit       cfg_v_s, cfg_b_s, mode_v_s, analog_b_s, lock_v_s, lock_b_s;

  item_t   event_q [$];
  bit      typed_q [$];
  result_t typed_res_q [$];
  result_t reply_q [$];
  int      errors = 0;
  int      accepted = 0;
  bit      hold_done = 1'b0;

  function automatic bit [7:0] id_now();
    if (config_s) return ID_CONFIG;
    if (!analog_s) return ID_DIGITAL;
    return pressure_s ? ID_PRESSURE : ID_ANALOG;
  endfunction

  function automatic bit [4:0] len_now();
    if (!analog_s) return 5'd5;
    return pressure_s ? 5'd21 : 5'd9;
  endfunction

  function automatic bit [7:0] poll_reply(bit [7:0] p);
    if (p == 3) return pad_s[0];
    if (p == 4) return pad_s[1];
    if (!analog_s) return 8'hFF;
    if (p >= 5 && p <= 8) return pad_s[p - 3];
    if (pressure_s && p >= 9 && p < 21) return pad_s[p - 3];
    return 8'h00;
  endfunction

  function automatic bit [7:0] table_at(logic [5:0][7:0] t, bit [7:0] p);
    return (p <= 8) ? t[p - 3] : 8'h00;
  endfunction

  // Reply bytes of configuration commands, from position 3 on.
  function automatic bit [7:0] cfg_reply(bit [7:0] p);
    logic [5:0][7:0] st;
    if (p < 3) return 8'h00;
    case (cmd_s)
      CMD_ATTR_READ:
        if (p == 5) return (arg_s < AttrCount) ? {6'd0, attr_s[arg_s]} : 8'hFF;
      CMD_CAPS: return table_at(TBL_CAPS, p);
      CMD_ENTER_CFG:
        if (!cfg_start_s) begin
          if (p == 3 || p == 4) return pad_s[p - 3];
          if (analog_s && p >= 5 && p <= 8) return pad_s[p - 3];
        end
      CMD_SET_MODE: return (p == 5 && arg_s > 1) ? 8'hFF : 8'h00;
      CMD_STATUS: begin
        st = {8'h00, 8'h01, 8'h02, {7'd0, analog_s}, 8'h02, 8'h03};
        return table_at(st, p);
      end
      CMD_CONST_46:
        if (arg_s == 0) return table_at(TBL_46A, p);
        else if (arg_s == 1) return table_at(TBL_46B, p);
      CMD_CONST_47: return table_at(TBL_47, p);
      CMD_CONST_48: return (p == 7 && arg_s <= 1) ? 8'h01 : 8'h00;
      CMD_CONST_4C:
        if (p == 6) return (arg_s == 0) ? 8'h04 : ((arg_s == 1) ? 8'h07 : 8'h00);
      CMD_MOTOR_MAP: return (p - 3 < 6) ? saved_map_s[p - 3] : 8'h00;
      CMD_RESP_MASK: return (p == 8) ? HDR_MARK : 8'h00;
      default: ;
    endcase
    return 8'h00;
  endfunction

  function automatic bit [7:0] reply_for(bit [7:0] p);
    if (!addressed_s || p == 0) return IDLE_BYTE;
    if (p == 1) return cfg_start_s ? ID_CONFIG : id_now();
    if (p == 2) return HDR_MARK;
    if (cmd_s == CMD_POLL) return poll_reply(p);
    if (cmd_s == CMD_ENTER_CFG && !cfg_start_s) return cfg_reply(p);
    if (!cfg_start_s) return 8'h00;
    return cfg_reply(p);
  endfunction

  // Exchange of one byte inside a frame.
  function automatic void take_byte(bit [7:0] rx);
    bit [7:0] p;
    int d;
    p = pos_s;
    d = int'(p) - 3;
    if (p == 3) arg_s = rx;
    if (p == 0) begin
      addressed_s = (rx == HDR_ADDR);
    end else if (p == 1 && addressed_s) begin
      cmd_s = rx;
    end else if (addressed_s && p >= 3) begin
      case (cmd_s)
        CMD_POLL:
          if (d < 6) begin
            if (map_s[d] == 8'h00) small_s = (rx == 8'hFF) ? 8'hFF : 8'h00;
            if (map_s[d] == 8'h01) large_s = rx;
          end
        CMD_ENTER_CFG:
          if (p == 3) begin
            cfg_v_s = 1'b1;
            cfg_b_s = (rx == 8'h01);
          end
        CMD_SET_MODE: begin
          if (p == 3 && rx <= 1) begin
            mode_v_s = 1'b1;
            analog_b_s = (rx == 8'h01);
          end
          if (p == 4) begin
            lock_v_s = 1'b1;
            lock_b_s = (rx[1:0] == 2'b11);
          end
        end
        CMD_MOTOR_MAP: if (d < 6) staged_map_s[d] = rx;
        CMD_RESP_MASK: if (d < 6) staged_mask_s[d] = rx;
        CMD_ATTR_READ: if (p == 4 && arg_s < AttrCount) attr_s[arg_s] = rx[1:0];
        default: ;
      endcase
    end
    if (pos_s != 8'hFF) pos_s++;
    tx_s = reply_for(pos_s);
  endfunction

  // Deselect: commit what the frame staged.
  function automatic void close_frame();
    bit [17:0] m;
    if (addressed_s) begin
      if (cmd_s == CMD_MOTOR_MAP && cfg_start_s) map_s = staged_map_s;
      if (cmd_s == CMD_RESP_MASK && cfg_start_s) begin
        mask_s = staged_mask_s;
        m = {mask_s[2][1:0], mask_s[1], mask_s[0]};
        pressure_s = (m[17:6] != 0);
      end
      if (cmd_s == CMD_SET_MODE && cfg_start_s) begin
        if (mode_v_s) analog_s = analog_b_s;
        if (lock_v_s) lock_s = lock_b_s;
        if (!analog_s) pressure_s = 1'b0;
      end
      if (cmd_s == CMD_ENTER_CFG && cfg_v_s) config_s = cfg_b_s;
    end
    addressed_s = 1'b0;
    tx_s = IDLE_BYTE;
  endfunction

  function automatic result_t responder_step(item_t ev);
    result_t r;
    case (ev.op)
      OP_START: begin
        pos_s = 0;
        addressed_s = 1'b0;
        cmd_s = 0;
        arg_s = 0;
        cfg_start_s = config_s;
        {cfg_v_s, cfg_b_s, mode_v_s, analog_b_s, lock_v_s, lock_b_s} = '0;
        tx_s = IDLE_BYTE;
        saved_map_s = map_s;
        staged_map_s = map_s;
        staged_mask_s = mask_s;
      end
      OP_BYTE: take_byte(ev.data_byte);
      OP_END: close_frame();
      default: if (ev.pad_index < 18) pad_s[ev.pad_index] = ev.pad_value;
    endcase
    r.tx_byte = tx_s;
    r.motor_small_drive = small_s;
    r.motor_large_drive = large_s;
    r.analog_on = analog_s;
    r.config_on = config_s;
    r.mode_lock_on = lock_s;
    r.pressure_on = pressure_s;
    r.device_id = id_now();
    r.poll_length = len_now();
    return r;
  endfunction

  function automatic void reset_shadow();
    analog_s = 1'b1;
    lock_s = 1'b1;
    config_s = 1'b0;
    pressure_s = 1'b0;
    foreach (pad_s[i]) pad_s[i] = (i < 2) ? 8'hFF : ((i < 6) ? 8'h80 : 8'h00);
    foreach (map_s[i]) begin
      map_s[i] = 8'hFF;
      mask_s[i] = (i == 0) ? 8'h3F : 8'h00;
      saved_map_s[i] = 0;
      staged_map_s[i] = 0;
      staged_mask_s[i] = 0;
    end
    foreach (attr_s[i]) attr_s[i] = 2'd2;
    {small_s, large_s, pos_s, cmd_s, arg_s} = '0;
    {addressed_s, cfg_start_s} = '0;
    {cfg_v_s, cfg_b_s, mode_v_s, analog_b_s, lock_v_s, lock_b_s} = '0;
    tx_s = IDLE_BYTE;
  endfunction

  // Builds a transaction from its four fields.
  function automatic item_t mk(op_e op, bit [7:0] data, bit [4:0] idx, bit [7:0] val);
    item_t it;
    it.op = op;
    it.data_byte = data;
    it.pad_index = idx;
    it.pad_value = val;
    return it;
  endfunction

  function automatic void queue_event(item_t it, bit typed, result_t res);
    event_q.push_back(it);
    typed_q.push_back(typed);
    typed_res_q.push_back(res);
  endfunction

  function automatic void queue_plain(item_t it);
    queue_event(it, 1'b0, '0);
  endfunction

  function automatic bit [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic bit [7:0] pick_command();
    case ($urandom_range(0, 17))
      0: return CMD_ATTR_READ;
      1: return CMD_CAPS;
      2, 3, 4: return CMD_POLL;
      5, 6, 7: return CMD_ENTER_CFG;
      8, 9: return CMD_SET_MODE;
      10: return CMD_STATUS;
      11: return CMD_CONST_46;
      12: return CMD_CONST_47;
      13: return CMD_CONST_48;
      14: return CMD_CONST_4C;
      15: return CMD_MOTOR_MAP;
      16: return CMD_RESP_MASK;
      default: return rnd8();
    endcase
  endfunction

  // One random frame: select, address, command, payload, mostly a deselect.
  function automatic void queue_frame();
    bit [7:0] cmd, b;
    int n;
    cmd = pick_command();
    n = ($urandom_range(0, 199) == 0) ? $urandom_range(260, 300) : $urandom_range(0, 22);
    queue_plain(mk(OP_START, rnd8(), 5'($urandom), rnd8()));
    queue_plain(mk(OP_BYTE, ($urandom_range(0, 9) != 0) ? HDR_ADDR : rnd8(),
                   5'($urandom), rnd8()));
    queue_plain(mk(OP_BYTE, cmd, 5'($urandom), rnd8()));
    for (int p = 2; p < n; p++) begin
      b = rnd8();
      if (p == 3 && (cmd == CMD_ENTER_CFG || cmd == CMD_SET_MODE || cmd == CMD_ATTR_READ ||
                     cmd == CMD_CONST_46) && $urandom_range(0, 3) != 0)
        b = 8'($urandom_range(0, (cmd == CMD_ATTR_READ) ? 13 : 2));
      if (cmd == CMD_MOTOR_MAP && $urandom_range(0, 1)) b = 8'($urandom_range(0, 1));
      if (cmd == CMD_RESP_MASK && $urandom_range(0, 2) == 0) b = 8'h00;
      if ($urandom_range(0, 19) == 0)
        queue_plain(mk(OP_PAD, rnd8(), 5'($urandom), rnd8()));
      queue_plain(mk(OP_BYTE, b, 5'($urandom), rnd8()));
    end
    if ($urandom_range(0, 9) != 0) queue_plain(mk(OP_END, rnd8(), 5'($urandom), rnd8()));
    if ($urandom_range(0, 9) == 0)
      queue_plain(mk(op_e'($urandom_range(0, 3)), rnd8(), 5'($urandom), rnd8()));
  endfunction

  // Directed table and the random frames after it.
  function automatic void build_stimulus();
    row_t rows [$];
    result_t idle;
    idle = '{IDLE_BYTE, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, ID_ANALOG, 5'd9};
    rows.push_back('{mk(OP_END, 8'h00, 5'd0, 8'h00), 1'b1, idle});
    rows.push_back('{mk(OP_PAD, 8'hFF, 5'd31, 8'hFF), 1'b1, idle});
    rows.push_back('{mk(OP_START, 8'hFF, 5'd31, 8'h00), 1'b1, idle});
    idle.tx_byte = ID_ANALOG;
    rows.push_back('{mk(OP_BYTE, HDR_ADDR, 5'd0, 8'h00), 1'b1, idle});
    rows.push_back('{mk(OP_BYTE, CMD_POLL, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_PAD, 8'h00, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_PAD, 8'h00, 5'd17, 8'hFF), 1'b0, idle});
    for (int i = 0; i < 6; i++)
      rows.push_back('{mk(OP_BYTE, 8'hFF, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_END, 8'h00, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_BYTE, 8'h01, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_END, 8'h00, 5'd0, 8'h00), 1'b0, idle});
    // Enter configuration mode, then an unaddressed frame.
    rows.push_back('{mk(OP_START, 8'h00, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_BYTE, HDR_ADDR, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_BYTE, CMD_ENTER_CFG, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_BYTE, 8'h00, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_BYTE, 8'h01, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_END, 8'h00, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_START, 8'h00, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_BYTE, 8'h02, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_BYTE, CMD_CAPS, 5'd0, 8'h00), 1'b0, idle});
    rows.push_back('{mk(OP_END, 8'h00, 5'd0, 8'h00), 1'b0, idle});
    foreach (rows[i]) queue_event(rows[i].ev, rows[i].typed, rows[i].res);
    while (event_q.size() < 1675) queue_frame();
  endfunction

  // Idle length: mostly none or short, a few long, with calm stretches.
  function automatic int pick_idle(int phase);
    int r;
    if ((phase / 150) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic void field_check(string name, bit [7:0] e, bit [7:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, e, a);
      errors++;
    end
  endfunction

  // Prediction on input acceptance, comparison on result acceptance.
  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        r = responder_step(in_item_i);
        if (typed_q.pop_front()) r = typed_res_q.pop_front();
        else void'(typed_res_q.pop_front());
        reply_q.push_back(r);
        accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %p", $time, out_item_o);
          errors++;
        end else begin
          r = reply_q.pop_front();
          field_check("tx_byte", r.tx_byte, out_item_o.tx_byte);
          field_check("motor_small_drive", r.motor_small_drive,
                      out_item_o.motor_small_drive);
          field_check("motor_large_drive", r.motor_large_drive,
                      out_item_o.motor_large_drive);
          field_check("analog_on", r.analog_on, out_item_o.analog_on);
          field_check("config_on", r.config_on, out_item_o.config_on);
          field_check("mode_lock_on", r.mode_lock_on, out_item_o.mode_lock_on);
          field_check("pressure_on", r.pressure_on, out_item_o.pressure_on);
          field_check("device_id", r.device_id, out_item_o.device_id);
          field_check("poll_length", r.poll_length, out_item_o.poll_length);
        end
      end
    end
  end

  // Receiver stalls, with one long hold-off while the sender keeps offering.
  initial begin
    int left;
    int cyc;
    left = 0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (left > 0) begin
        out_stall_i <= 1'b1;
        left--;
      end else begin
        out_stall_i <= 1'b0;
        if (!hold_done && accepted >= 700) begin
          hold_done = 1'b1;
          left = 80;
        end else begin
          left = pick_idle(cyc + 75);
        end
      end
    end
  end

  // Reset, then the sender walks the stimulus.
  initial begin
    item_t it;
    int g;
    int n;
    reset_shadow();
    build_stimulus();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    n = 0;
    foreach (event_q[i]) begin
      it = event_q[i];
      g = pick_idle(n);
      n++;
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_item_i <= it;
      do @(posedge clk_i); while (in_stall_o);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
    wait (reply_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // Timeout guard.
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
